// ----- sv/chip8_instruction_executor_defines.svh -----
// Assertion macros shared by the executor RTL.
// Depends on nothing; the using module supplies clk and rst_n.
`ifndef CHIP8_INSTRUCTION_EXECUTOR_DEFINES_SVH
`define CHIP8_INSTRUCTION_EXECUTOR_DEFINES_SVH
`ifndef SYNTHESIS
`define C8X_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define C8X_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define C8X_ASSERT_IMP(lbl, ante, cons, msg)
`define C8X_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// ----- sv/c8x_pkg.sv -----
// Types, constants, font table and decoder for the CHIP-8 executor.
// Depends on nothing.
package c8x_pkg;

  localparam int MEM_BYTES   = 4096;
  localparam int MEM_AW      = $clog2(MEM_BYTES);
  localparam int DISP_W      = 64;
  localparam int DISP_H      = 32;
  localparam int PIXELS      = DISP_W * DISP_H;
  localparam int PIX_AW      = $clog2(PIXELS);
  localparam int STACK_DEPTH = 16;
  localparam int SP_W        = $clog2(STACK_DEPTH);
  localparam int FONT_BYTES  = 80;
  localparam int NUM_REGS    = 16;

  localparam logic [MEM_AW-1:0] PC_RESET = 12'h200;

  localparam logic [1:0] CMD_EXEC  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_PIXEL = 2'd2;

  localparam logic [3:0] OP_SYS  = 4'h0;
  localparam logic [3:0] OP_JP   = 4'h1;
  localparam logic [3:0] OP_CALL = 4'h2;
  localparam logic [3:0] OP_SE   = 4'h3;
  localparam logic [3:0] OP_SNE  = 4'h4;
  localparam logic [3:0] OP_SER  = 4'h5;
  localparam logic [3:0] OP_LD   = 4'h6;
  localparam logic [3:0] OP_ADD  = 4'h7;
  localparam logic [3:0] OP_ALU  = 4'h8;
  localparam logic [3:0] OP_LDI  = 4'hA;
  localparam logic [3:0] OP_RND  = 4'hC;
  localparam logic [3:0] OP_DRW  = 4'hD;
  localparam logic [3:0] OP_KEY  = 4'hE;
  localparam logic [3:0] OP_MISC = 4'hF;

  localparam logic [3:0] SYS_CLS = 4'h0;
  localparam logic [3:0] SYS_RET = 4'hE;
  localparam logic [3:0] ALU_MOV = 4'h0;
  localparam logic [3:0] ALU_OR  = 4'h1;
  localparam logic [3:0] ALU_AND = 4'h2;
  localparam logic [3:0] ALU_ADC = 4'h4;
  localparam logic [3:0] ALU_SUB = 4'h5;
  localparam logic [7:0] KEY_SKP  = 8'h9E;
  localparam logic [7:0] KEY_SKNP = 8'hA1;
  localparam logic [7:0] F_LDDT  = 8'h07;
  localparam logic [7:0] F_SETDT = 8'h15;
  localparam logic [7:0] F_SETST = 8'h18;
  localparam logic [7:0] F_FONT  = 8'h29;
  localparam logic [7:0] F_BCD   = 8'h33;
  localparam logic [7:0] F_FILL  = 8'h65;

  localparam logic [7:0] FONT [FONT_BYTES] = '{
    8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
    8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
    8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
    8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
    8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
    8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
    8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
    8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
  };

  typedef enum logic [4:0] {
    CLS_CLS, CLS_RET, CLS_JP, CLS_CALL, CLS_SE, CLS_SNE, CLS_SER, CLS_LD,
    CLS_ADD, CLS_MOV, CLS_OR, CLS_AND, CLS_ADDC, CLS_SUB, CLS_LDI, CLS_RND,
    CLS_DRW, CLS_SKP, CLS_SKNP, CLS_LDDT, CLS_SETDT, CLS_SETST, CLS_FONT,
    CLS_BCD, CLS_FILL, CLS_BAD
  } opclass_t;

  typedef enum logic [4:0] {
    UOP_NONE, UOP_INIT, UOP_ACCEPT, UOP_PIX, UOP_F1, UOP_F2, UOP_F3, UOP_F4,
    UOP_EXEC, UOP_CLR, UOP_DMEM, UOP_DLAT, UOP_DPRD, UOP_DPWR, UOP_WRVF,
    UOP_BCD1, UOP_BCD2, UOP_BCD3, UOP_FRD, UOP_FWR, UOP_TICK, UOP_REPLY
  } uop_t;

  typedef enum logic [4:0] {
    ST_INIT, ST_IDLE, ST_PIX, ST_F1, ST_F2, ST_F3, ST_F4, ST_EXEC, ST_CLR,
    ST_DMEM, ST_DLAT, ST_DPRD, ST_DPWR, ST_WRVF, ST_BCD1, ST_BCD2, ST_BCD3,
    ST_FRD, ST_FWR, ST_TICK, ST_REPLY
  } state_t;

  typedef struct packed {
    uop_t uop;
  } cmd_t;

  typedef struct packed {
    opclass_t cls;
    logic     cnt_last;
    logic     col_last;
    logic     row_last;
    logic     rows_zero;
    logic     bit_set;
    logic     fill_last;
  } status_t;

  function automatic opclass_t decode_op(logic [15:0] w);
    opclass_t c;
    c = CLS_BAD;
    case (w[15:12])
      OP_SYS: begin
        if (w[3:0] == SYS_CLS) c = CLS_CLS;
        else if (w[3:0] == SYS_RET) c = CLS_RET;
      end
      OP_JP:   c = CLS_JP;
      OP_CALL: c = CLS_CALL;
      OP_SE:   c = CLS_SE;
      OP_SNE:  c = CLS_SNE;
      OP_SER:  c = CLS_SER;
      OP_LD:   c = CLS_LD;
      OP_ADD:  c = CLS_ADD;
      OP_ALU: begin
        case (w[3:0])
          ALU_MOV: c = CLS_MOV;
          ALU_OR:  c = CLS_OR;
          ALU_AND: c = CLS_AND;
          ALU_ADC: c = CLS_ADDC;
          ALU_SUB: c = CLS_SUB;
          default: c = CLS_BAD;
        endcase
      end
      OP_LDI: c = CLS_LDI;
      OP_RND: c = CLS_RND;
      OP_DRW: c = CLS_DRW;
      OP_KEY: begin
        if (w[7:0] == KEY_SKP) c = CLS_SKP;
        else if (w[7:0] == KEY_SKNP) c = CLS_SKNP;
      end
      OP_MISC: begin
        case (w[7:0])
          F_LDDT:  c = CLS_LDDT;
          F_SETDT: c = CLS_SETDT;
          F_SETST: c = CLS_SETST;
          F_FONT:  c = CLS_FONT;
          F_BCD:   c = CLS_BCD;
          F_FILL:  c = CLS_FILL;
          default: c = CLS_BAD;
        endcase
      end
      default: c = CLS_BAD;
    endcase
    return c;
  endfunction

endpackage

// ----- sv/chip8_instruction_executor.sv -----
// CHIP-8 executor top: sequencer plus datapath. After reset an init pass
// clears the display, loads the font and zeroes V0..VF; no beat is taken then.
// Write and undefined commands go to the reply; pixel reads the display first.
// Execute fetches and reads operands, then adds a VF write, BCD stores, a read
// and write per fill register, a clear pass, or per-row and per-bit draw steps.
// One beat at a time: the next beat is taken once the result is registered.
module chip8_instruction_executor
  import c8x_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_cmd,
  input  logic [11:0] in_address,
  input  logic [7:0]  in_write_byte,
  input  logic [15:0] in_keys_pressed,
  input  logic [7:0]  in_random_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [11:0] out_program_counter,
  output logic [15:0] out_last_opcode,
  output logic        out_display_changed,
  output logic        out_unknown_opcode,
  output logic        out_sound_active,
  output logic        out_pixel_value
);

  cmd_t    ctl;
  status_t st;

  c8x_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_cmd(in_cmd), .out_valid(out_valid), .out_ready(out_ready),
    .st(st), .ctl(ctl)
  );

  c8x_dp u_dp (
    .clk(clk), .rst_n(rst_n), .ctl(ctl), .st(st),
    .in_cmd(in_cmd), .in_address(in_address), .in_write_byte(in_write_byte),
    .in_keys_pressed(in_keys_pressed), .in_random_byte(in_random_byte),
    .out_program_counter(out_program_counter), .out_last_opcode(out_last_opcode),
    .out_display_changed(out_display_changed),
    .out_unknown_opcode(out_unknown_opcode),
    .out_sound_active(out_sound_active), .out_pixel_value(out_pixel_value)
  );

endmodule

// ----- sv/c8x_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module c8x_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

// ----- sv/c8x_ctrl.sv -----
// Sequencer for the executor: walks fetch, decode, execute and reply steps.
// Depends on c8x_pkg and the assertion macro header.
`include "chip8_instruction_executor_defines.svh"
module c8x_ctrl
  import c8x_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_cmd,
  output logic       out_valid,
  input  logic       out_ready,
  input  status_t    st,
  output cmd_t       ctl
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   reply_go;

  assign reply_go  = (state_r == ST_REPLY) && (!out_valid_r || out_ready);
  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_INIT: if (st.cnt_last) state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (in_valid) begin
          case (in_cmd)
            CMD_EXEC:  state_nxt = ST_F1;
            CMD_PIXEL: state_nxt = ST_PIX;
            default:   state_nxt = ST_REPLY;
          endcase
        end
      end
      ST_PIX:  state_nxt = ST_REPLY;
      ST_F1:   state_nxt = ST_F2;
      ST_F2:   state_nxt = ST_F3;
      ST_F3:   state_nxt = ST_F4;
      ST_F4:   state_nxt = ST_EXEC;
      ST_EXEC: begin
        case (st.cls)
          CLS_CLS:  state_nxt = ST_CLR;
          CLS_DRW:  state_nxt = st.rows_zero ? ST_WRVF : ST_DMEM;
          CLS_ADDC: state_nxt = ST_WRVF;
          CLS_SUB:  state_nxt = ST_WRVF;
          CLS_BCD:  state_nxt = ST_BCD1;
          CLS_FILL: state_nxt = ST_FRD;
          default:  state_nxt = ST_TICK;
        endcase
      end
      ST_CLR:  if (st.cnt_last) state_nxt = ST_TICK;
      ST_DMEM: state_nxt = ST_DLAT;
      ST_DLAT: state_nxt = ST_DPRD;
      ST_DPRD, ST_DPWR: begin
        if (state_r == ST_DPRD && st.bit_set) state_nxt = ST_DPWR;
        else if (st.col_last && st.row_last) state_nxt = ST_WRVF;
        else if (st.col_last) state_nxt = ST_DMEM;
        else state_nxt = ST_DPRD;
      end
      ST_WRVF: state_nxt = ST_TICK;
      ST_BCD1: state_nxt = ST_BCD2;
      ST_BCD2: state_nxt = ST_BCD3;
      ST_BCD3: state_nxt = ST_TICK;
      ST_FRD:  state_nxt = ST_FWR;
      ST_FWR:  state_nxt = st.fill_last ? ST_TICK : ST_FRD;
      ST_TICK: state_nxt = ST_REPLY;
      ST_REPLY: if (reply_go) state_nxt = ST_IDLE;
      default: state_nxt = ST_INIT;
    endcase
  end

  always_comb begin
    ctl.uop = UOP_NONE;
    case (state_r)
      ST_INIT:  ctl.uop = UOP_INIT;
      ST_IDLE:  if (in_valid) ctl.uop = UOP_ACCEPT;
      ST_PIX:   ctl.uop = UOP_PIX;
      ST_F1:    ctl.uop = UOP_F1;
      ST_F2:    ctl.uop = UOP_F2;
      ST_F3:    ctl.uop = UOP_F3;
      ST_F4:    ctl.uop = UOP_F4;
      ST_EXEC:  ctl.uop = UOP_EXEC;
      ST_CLR:   ctl.uop = UOP_CLR;
      ST_DMEM:  ctl.uop = UOP_DMEM;
      ST_DLAT:  ctl.uop = UOP_DLAT;
      ST_DPRD:  ctl.uop = UOP_DPRD;
      ST_DPWR:  ctl.uop = UOP_DPWR;
      ST_WRVF:  ctl.uop = UOP_WRVF;
      ST_BCD1:  ctl.uop = UOP_BCD1;
      ST_BCD2:  ctl.uop = UOP_BCD2;
      ST_BCD3:  ctl.uop = UOP_BCD3;
      ST_FRD:   ctl.uop = UOP_FRD;
      ST_FWR:   ctl.uop = UOP_FWR;
      ST_TICK:  ctl.uop = UOP_TICK;
      ST_REPLY: if (reply_go) ctl.uop = UOP_REPLY;
      default:  ctl.uop = UOP_NONE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    if (reply_go) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `C8X_ASSERT_IMP(a_exec_after_fetch, state_r == ST_EXEC, $past(state_r) == ST_F4, "exec without fetch")
  `C8X_ASSERT_NXT(a_reply_loads, state_r == ST_REPLY && !out_valid_r, out_valid_r && state_r == ST_IDLE, "reply not loaded")
  `C8X_ASSERT_NXT(a_exec_fetches, in_valid && in_ready && in_cmd == CMD_EXEC, state_r == ST_F1, "exec beat not fetched")
  `C8X_ASSERT_NXT(a_vf_then_tick, state_r == ST_WRVF, state_r == ST_TICK, "flag write not followed by tick")

endmodule

// ----- sv/c8x_dp.sv -----
// Datapath: program, register and display memories, PC, index, stack, timers.
// Depends on c8x_pkg and c8x_ram.
module c8x_dp
  import c8x_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  cmd_t        ctl,
  output status_t     st,
  input  logic [1:0]  in_cmd,
  input  logic [11:0] in_address,
  input  logic [7:0]  in_write_byte,
  input  logic [15:0] in_keys_pressed,
  input  logic [7:0]  in_random_byte,
  output logic [11:0] out_program_counter,
  output logic [15:0] out_last_opcode,
  output logic        out_display_changed,
  output logic        out_unknown_opcode,
  output logic        out_sound_active,
  output logic        out_pixel_value
);

  logic [MEM_AW-1:0] pc_r, i_r;
  logic [SP_W-1:0]   sp_r, spp1, spm1;
  logic [MEM_AW-1:0] stack_r [STACK_DEPTH];
  logic [7:0]        delay_r, sound_r;
  logic [15:0]       op_r;
  logic [7:0]        vx_r, vy_r, keys_sel, rnd_r, bits_r;
  logic [15:0]       keys_r;
  logic              pix_ok_r, flag_r, chg_r, unk_r, pix_r;
  logic [PIX_AW-1:0] cnt_r;
  logic [3:0]        row_r, k_r;
  logic [2:0]        col_r;
  logic [4:0]        tq_r;
  opclass_t          cls;

  logic [MEM_AW-1:0] pc_nxt;
  logic              held;
  logic [8:0]        sum9;
  logic              exec_we;
  logic [7:0]        exec_wdata;
  logic [15:0]       q1_prod;
  logic [12:0]       q2_prod;
  logic [1:0]        hund;
  logic [3:0]        tens, ones;
  logic [4:0]        ry;
  logic [PIX_AW-1:0] pix_at;
  logic              adv;

  logic              mem_we;
  logic [MEM_AW-1:0] mem_waddr, mem_raddr;
  logic [7:0]        mem_wdata, mem_rdata;
  logic              disp_we, disp_wdata, disp_rdata;
  logic [PIX_AW-1:0] disp_waddr, disp_raddr;
  logic              reg_we;
  logic [3:0]        reg_waddr, reg_raddr;
  logic [7:0]        reg_wdata, reg_rdata;

  assign cls  = decode_op(op_r);
  assign spp1 = (sp_r == SP_W'(STACK_DEPTH - 1)) ? '0 : sp_r + 1'b1;
  assign spm1 = (sp_r == '0) ? SP_W'(STACK_DEPTH - 1) : sp_r - 1'b1;
  assign keys_sel = 8'(keys_r >> vx_r[3:0]);
  assign held = (vx_r[7:4] == 4'd0) && keys_sel[0];
  assign sum9 = {1'b0, vx_r} + {1'b0, vy_r};
  assign ry   = vy_r[4:0] + {1'b0, row_r};
  assign pix_at = {3'b0, vx_r} + {8'b0, col_r} + {ry, 6'b0};
  assign q1_prod = {8'b0, vx_r} * 16'd205;
  assign q2_prod = {8'b0, tq_r} * 13'd205;
  assign hund = q2_prod[12:11];
  assign tens = 4'(tq_r - 5'({hund, 3'b0} + {hund, 1'b0}));
  assign ones = 4'(vx_r - 8'({tq_r, 3'b0} + {tq_r, 1'b0}));
  assign adv  = (ctl.uop == UOP_DPRD && !st.bit_set) || ctl.uop == UOP_DPWR;

  assign st.cls       = cls;
  assign st.cnt_last  = (cnt_r == PIX_AW'(PIXELS - 1));
  assign st.col_last  = (col_r == 3'd7);
  assign st.row_last  = (row_r == op_r[3:0] - 4'd1);
  assign st.rows_zero = (op_r[3:0] == 4'd0);
  assign st.bit_set   = bits_r[3'd7 - col_r];
  assign st.fill_last = (k_r == op_r[11:8]);

  always_comb begin
    pc_nxt     = pc_r + 12'd2;
    exec_we    = 1'b0;
    exec_wdata = op_r[7:0];
    case (cls)
      CLS_RET:  pc_nxt = stack_r[spm1] + 12'd2;
      CLS_JP:   pc_nxt = op_r[11:0];
      CLS_CALL: pc_nxt = op_r[11:0];
      CLS_SE:   if (vx_r == op_r[7:0]) pc_nxt = pc_r + 12'd4;
      CLS_SNE:  if (vx_r != op_r[7:0]) pc_nxt = pc_r + 12'd4;
      CLS_SER:  if (vx_r == vy_r) pc_nxt = pc_r + 12'd4;
      CLS_SKP:  if (held) pc_nxt = pc_r + 12'd4;
      CLS_SKNP: if (!held) pc_nxt = pc_r + 12'd4;
      CLS_LD:   exec_we = 1'b1;
      CLS_ADD:  begin exec_we = 1'b1; exec_wdata = vx_r + op_r[7:0]; end
      CLS_MOV:  begin exec_we = 1'b1; exec_wdata = vy_r; end
      CLS_OR:   begin exec_we = 1'b1; exec_wdata = vx_r | vy_r; end
      CLS_AND:  begin exec_we = 1'b1; exec_wdata = vx_r & vy_r; end
      CLS_ADDC: begin exec_we = 1'b1; exec_wdata = sum9[7:0]; end
      CLS_SUB:  begin exec_we = 1'b1; exec_wdata = vx_r - vy_r; end
      CLS_RND:  begin exec_we = 1'b1; exec_wdata = rnd_r & op_r[7:0]; end
      CLS_LDDT: begin exec_we = 1'b1; exec_wdata = delay_r; end
      CLS_BAD:  pc_nxt = pc_r;
      default:  pc_nxt = pc_r + 12'd2;
    endcase
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = i_r;
    mem_wdata = in_write_byte;
    mem_raddr = pc_r;
    disp_we    = 1'b0;
    disp_waddr = cnt_r;
    disp_wdata = 1'b0;
    disp_raddr = pix_at;
    reg_we    = 1'b0;
    reg_waddr = op_r[11:8];
    reg_wdata = exec_wdata;
    reg_raddr = op_r[11:8];
    case (ctl.uop)
      UOP_INIT: begin
        disp_we   = 1'b1;
        mem_we    = (cnt_r < PIX_AW'(FONT_BYTES));
        mem_waddr = MEM_AW'(cnt_r);
        mem_wdata = (cnt_r < PIX_AW'(FONT_BYTES)) ? FONT[cnt_r[6:0]] : 8'd0;
        reg_we    = (cnt_r < PIX_AW'(NUM_REGS));
        reg_waddr = cnt_r[3:0];
        reg_wdata = 8'd0;
      end
      UOP_ACCEPT: begin
        mem_we     = (in_cmd == CMD_WRITE);
        mem_waddr  = in_address;
        mem_raddr  = pc_r;
        disp_raddr = in_address[PIX_AW-1:0];
      end
      UOP_F1:   mem_raddr = pc_r + 12'd1;
      UOP_F2:   reg_raddr = op_r[11:8];
      UOP_F3:   reg_raddr = op_r[7:4];
      UOP_EXEC: reg_we = exec_we;
      UOP_CLR:  disp_we = 1'b1;
      UOP_DMEM: mem_raddr = i_r + {8'b0, row_r};
      UOP_DPRD: disp_raddr = pix_at;
      UOP_DPWR: begin
        disp_we    = 1'b1;
        disp_waddr = pix_at;
        disp_wdata = ~disp_rdata;
      end
      UOP_WRVF: begin
        reg_we    = 1'b1;
        reg_waddr = 4'hF;
        reg_wdata = {7'd0, flag_r};
      end
      UOP_BCD1: begin mem_we = 1'b1; mem_wdata = {6'd0, hund}; end
      UOP_BCD2: begin
        mem_we = 1'b1; mem_waddr = i_r + 12'd1; mem_wdata = {4'd0, tens};
      end
      UOP_BCD3: begin
        mem_we = 1'b1; mem_waddr = i_r + 12'd2; mem_wdata = {4'd0, ones};
      end
      UOP_FRD:  mem_raddr = i_r + {8'b0, k_r};
      UOP_FWR: begin
        reg_we    = 1'b1;
        reg_waddr = k_r;
        reg_wdata = mem_rdata;
      end
      default: mem_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r    <= PC_RESET;
      i_r     <= '0;
      sp_r    <= '0;
      delay_r <= '0;
      sound_r <= '0;
      cnt_r   <= '0;
      for (int s = 0; s < STACK_DEPTH; s++) stack_r[s] <= '0;
    end else begin
      case (ctl.uop)
        UOP_INIT, UOP_CLR: cnt_r <= cnt_r + 1'b1;
        UOP_ACCEPT: begin
          op_r     <= '0;
          chg_r    <= 1'b0;
          unk_r    <= 1'b0;
          pix_r    <= 1'b0;
          keys_r   <= in_keys_pressed;
          rnd_r    <= in_random_byte;
          pix_ok_r <= (in_address < 12'(PIXELS));
        end
        UOP_PIX: pix_r <= pix_ok_r & disp_rdata;
        UOP_F1:  op_r[15:8] <= mem_rdata;
        UOP_F2:  op_r[7:0]  <= mem_rdata;
        UOP_F3:  vx_r <= reg_rdata;
        UOP_F4:  vy_r <= reg_rdata;
        UOP_EXEC: begin
          pc_r  <= pc_nxt;
          cnt_r <= '0;
          row_r <= '0;
          col_r <= '0;
          k_r   <= '0;
          tq_r  <= q1_prod[15:11];
          case (cls)
            CLS_CLS:   chg_r <= 1'b1;
            CLS_RET:   sp_r <= spm1;
            CLS_CALL: begin
              stack_r[sp_r] <= pc_r;
              sp_r          <= spp1;
            end
            CLS_ADDC:  flag_r <= sum9[8];
            CLS_SUB:   flag_r <= (vx_r >= vy_r);
            CLS_LDI:   i_r <= op_r[11:0];
            CLS_DRW: begin
              flag_r <= 1'b0;
              chg_r  <= 1'b1;
            end
            CLS_SETDT: delay_r <= vx_r;
            CLS_SETST: sound_r <= vx_r;
            CLS_FONT:  i_r <= 12'({4'b0, vx_r} * 12'd5);
            CLS_BAD:   unk_r <= 1'b1;
            default:   chg_r <= 1'b0;
          endcase
        end
        UOP_DLAT: begin
          bits_r <= mem_rdata;
          col_r  <= '0;
        end
        UOP_FWR: k_r <= k_r + 1'b1;
        UOP_TICK: begin
          if (delay_r != 8'd0) delay_r <= delay_r - 1'b1;
          if (sound_r != 8'd0) sound_r <= sound_r - 1'b1;
        end
        UOP_REPLY: begin
          out_program_counter <= pc_r;
          out_last_opcode     <= op_r;
          out_display_changed <= chg_r;
          out_unknown_opcode  <= unk_r;
          out_sound_active    <= (sound_r != 8'd0);
          out_pixel_value     <= pix_r;
        end
        default: cnt_r <= cnt_r;
      endcase
      if (ctl.uop == UOP_DPWR) flag_r <= flag_r | disp_rdata;
      if (adv) begin
        if (st.col_last) begin
          col_r <= '0;
          row_r <= row_r + 1'b1;
        end else begin
          col_r <= col_r + 1'b1;
        end
      end
    end
  end

  c8x_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_mem (
    .clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
    .raddr(mem_raddr), .rdata(mem_rdata)
  );

  c8x_ram #(.WIDTH(1), .DEPTH(PIXELS)) u_disp (
    .clk(clk), .we(disp_we), .waddr(disp_waddr), .wdata(disp_wdata),
    .raddr(disp_raddr), .rdata(disp_rdata)
  );

  c8x_ram #(.WIDTH(8), .DEPTH(NUM_REGS)) u_regs (
    .clk(clk), .we(reg_we), .waddr(reg_waddr), .wdata(reg_wdata),
    .raddr(reg_raddr), .rdata(reg_rdata)
  );

endmodule
